[rtl/core/svr_pkg.sv]
// shared types, codes and the log2 fraction function for the c/n0 estimator
package svr_pkg;

    localparam int PWR_W      = 64;
    localparam int MUL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_BW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CN0 = 2'd2;

    localparam logic [2:0] OUTC_UPDATED    = 3'd0;
    localparam logic [2:0] OUTC_FIRST      = 3'd1;
    localparam logic [2:0] OUTC_ZERO_SIG   = 3'd2;
    localparam logic [2:0] OUTC_NEG_NOISE  = 3'd3;
    localparam logic [2:0] OUTC_RESTART    = 3'd4;

    localparam logic [MUL_W-1:0] TEN_LOG10_2_Q16 = 32'd197283;
    localparam logic signed [15:0] CN0_MAX = 16'sh7fff;
    localparam logic signed [15:0] CN0_MIN = -16'sh8000;

    localparam logic [16:0] ALPHA_RESET    = 17'd655;
    localparam logic signed [15:0] LOG_BW_RESET   = 16'sd7680;
    localparam logic signed [15:0] INIT_CN0_RESET = 16'sd0;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_FIRST,
        KIND_RESTART
    } kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // log2(1 + f/2^lfb) by square-and-compare, evaluated on constants only
    function automatic logic [31:0] frac_rom(input int unsigned f, input int unsigned lfb);
        logic [63:0] y;
        logic [31:0] r;
        y = ((64'd1 << lfb) + 64'(f)) << (30 - lfb);
        r = 32'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (i < lfb)
            begin
                y = (y * y) >> 30;
                r = {r[30:0], 1'b0};
                if (y >= 64'h8000_0000)
                begin
                    r[0] = 1'b1;
                    y = y >> 1;
                end
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/svr_ifs.sv]
// handshake channel interfaces: samples, results, configuration writes
interface svr_sample_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] in_phase;
    logic signed [SAMPLE_BITS-1:0] quadrature;
    modport source (output valid, action, in_phase, quadrature, input ready);
    modport sink (input valid, action, in_phase, quadrature, output ready);
endinterface

interface svr_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cn0_dbhz;
    logic [2:0]         outcome;
    modport source (output valid, cn0_dbhz, outcome, input ready);
    modport sink (input valid, cn0_dbhz, outcome, output ready);
endinterface

interface svr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/svr_fifo.sv]
// two-entry queue between the front and the back
module svr_fifo #(
    parameter int W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [W-1:0]          push_data,
    input  logic                  pop,
    output logic [W-1:0]          pop_data,
    output svr_pkg::fifo_status_t status
);
    import svr_pkg::*;

    logic [W-1:0] mem [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

[rtl/core/svr_front.sv]
// front: accepts beats, takes magnitudes, classifies and keeps the previous sample
module svr_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    svr_sample_if.sink             samples,
    input  svr_pkg::fifo_status_t  status,
    output logic                   push,
    output svr_pkg::kind_t         kind,
    output logic [SAMPLE_BITS-1:0] i_mag,
    output logic [SAMPLE_BITS-1:0] q_mag,
    output logic [SAMPLE_BITS-1:0] prev_i_mag,
    output logic [SAMPLE_BITS-1:0] prev_q_mag
);
    import svr_pkg::*;

    logic [SAMPLE_BITS-1:0] prev_i_reg;
    logic [SAMPLE_BITS-1:0] prev_q_reg;
    logic                   have_prev_reg;

    assign samples.ready = !status.full;
    assign push          = samples.valid && !status.full;

    // two's complement negate gives the right unsigned magnitude at the most negative code
    assign i_mag = samples.in_phase[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samples.in_phase)
                                                  : SAMPLE_BITS'(samples.in_phase);
    assign q_mag = samples.quadrature[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samples.quadrature)
                                                    : SAMPLE_BITS'(samples.quadrature);
    assign prev_i_mag = prev_i_reg;
    assign prev_q_mag = prev_q_reg;

    always_comb
    begin
        if (samples.action)
        begin
            kind = KIND_RESTART;
        end
        else if (!have_prev_reg)
        begin
            kind = KIND_FIRST;
        end
        else
        begin
            kind = KIND_SAMPLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (push)
        begin
            if (samples.action)
            begin
                prev_i_reg    <= '0;
                prev_q_reg    <= '0;
                have_prev_reg <= 1'b0;
            end
            else
            begin
                prev_i_reg    <= i_mag;
                prev_q_reg    <= q_mag;
                have_prev_reg <= 1'b1;
            end
        end
    end

endmodule

[rtl/core/svr_back.sv]
// back: power smoothing, log2 ratio and c/n0 result on one shared multiplier
module svr_back #(
    parameter int SAMPLE_BITS   = 16,
    parameter int ALPHA_BITS    = 16,
    parameter int LOG_FRAC_BITS = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  svr_pkg::fifo_status_t  status,
    output logic                   pop,
    input  svr_pkg::kind_t         kind,
    input  logic [SAMPLE_BITS-1:0] i_mag,
    input  logic [SAMPLE_BITS-1:0] q_mag,
    input  logic [SAMPLE_BITS-1:0] prev_i_mag,
    input  logic [SAMPLE_BITS-1:0] prev_q_mag,
    input  logic [ALPHA_BITS:0]    alpha,
    input  logic signed [15:0]     log_bw,
    input  logic signed [15:0]     init_cn0,
    svr_result_if.source           results
);
    import svr_pkg::*;

    localparam int AW   = ALPHA_BITS + 1;
    localparam int LG_W = 6 + LOG_FRAC_BITS;
    localparam int D_W  = LG_W + 1;
    localparam int ROM_N = 2 ** LOG_FRAC_BITS;

    typedef enum logic [4:0] {
        B_IDLE, B_SQI, B_SQQ, B_SPI, B_SPQ, B_XS, B_XT,
        B_DIF, B_LO, B_HI, B_UPD, B_CHK, B_NORM, B_LOG, B_TERM, B_FIN, B_OUT
    } state_t;

    state_t                 state_reg;
    logic [SAMPLE_BITS-1:0] im_reg, qm_reg, pim_reg, pqm_reg;
    logic [MUL_W-1:0]       t_reg, s2_reg, sp_reg;
    logic [PWR_W-1:0]       xs_reg, xt_reg, m_reg, p1_reg, p2_reg;
    logic [PWR_W-1:0]       sig_reg, tot_reg;
    logic [PWR_W-1:0]       vn_reg, vs_reg;
    logic [5:0]             kn_reg, ks_reg;
    logic [2:0]             step_reg;
    logic                   which_reg, neg_reg;
    logic signed [D_W-1:0]  d_reg;
    logic signed [15:0]     est_reg;
    logic [2:0]             oc_reg;
    logic                   ov_reg;
    logic signed [15:0]     out_cn0_reg;
    logic [2:0]             out_oc_reg;

    logic [LOG_FRAC_BITS-1:0] rom [ROM_N];
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [PWR_W-1:0]         mul_p;
    logic [AW-1:0]            a_sat;
    logic [PWR_W-1:0]         p_cur, x_cur, p_new, q_val;
    logic [PWR_W+31:0]        full;
    logic                     rem_nz;
    logic [6:0]               sh;
    logic [PWR_W-1:0]         top_mask;
    logic [LG_W-1:0]          lgn, lgs;
    logic [D_W-1:0]           d_abs;
    logic [PWR_W-1:0]         rounded;
    logic signed [32:0]       term, res;
    logic                     out_free;

    for (genvar g = 0; g < ROM_N; g++)
    begin : g_rom
        assign rom[g] = LOG_FRAC_BITS'(frac_rom(g, LOG_FRAC_BITS));
    end

    assign a_sat = (alpha > (AW'(1) << ALPHA_BITS)) ? (AW'(1) << ALPHA_BITS) : alpha;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_SQI:   begin mul_a = MUL_W'(im_reg);  mul_b = MUL_W'(im_reg);  end
            B_SQQ:   begin mul_a = MUL_W'(qm_reg);  mul_b = MUL_W'(qm_reg);  end
            B_SPI:   begin mul_a = MUL_W'(pim_reg); mul_b = MUL_W'(pim_reg); end
            B_SPQ:   begin mul_a = MUL_W'(pqm_reg); mul_b = MUL_W'(pqm_reg); end
            B_XS:    begin mul_a = s2_reg;          mul_b = sp_reg;          end
            B_XT:    begin mul_a = s2_reg;          mul_b = s2_reg;          end
            B_LO:    begin mul_a = m_reg[31:0];     mul_b = MUL_W'(a_sat);   end
            B_HI:    begin mul_a = m_reg[63:32];    mul_b = MUL_W'(a_sat);   end
            B_TERM:  begin mul_a = MUL_W'(d_abs);   mul_b = TEN_LOG10_2_Q16; end
            default: begin mul_a = '0;              mul_b = '0;              end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // smoothing step: p +/- floor((x - p) * alpha / 2^ALPHA_BITS)
    assign p_cur  = which_reg ? tot_reg : sig_reg;
    assign x_cur  = which_reg ? xt_reg : xs_reg;
    assign full   = {p2_reg, 32'd0} + (PWR_W + 32)'(p1_reg);
    assign q_val  = PWR_W'(full >> ALPHA_BITS);
    assign rem_nz = (p1_reg[ALPHA_BITS-1:0] != '0);
    assign p_new  = neg_reg ? (p_cur - q_val - PWR_W'(rem_nz)) : (p_cur + q_val);

    // normalize search: test the top sh bits of both words
    assign sh       = 7'd32 >> step_reg;
    assign top_mask = ~({PWR_W{1'b1}} >> sh);

    assign lgn   = {kn_reg, {LOG_FRAC_BITS{1'b0}}}
                   + LG_W'(rom[vn_reg[PWR_W-2 -: LOG_FRAC_BITS]]);
    assign lgs   = {ks_reg, {LOG_FRAC_BITS{1'b0}}}
                   + LG_W'(rom[vs_reg[PWR_W-2 -: LOG_FRAC_BITS]]);
    assign d_abs = d_reg[D_W-1] ? D_W'(-d_reg) : D_W'(d_reg);

    assign rounded = (m_reg + (PWR_W'(1) << (LOG_FRAC_BITS + 7))) >> (LOG_FRAC_BITS + 8);
    assign term    = neg_reg ? -$signed({1'b0, rounded[31:0]}) : $signed({1'b0, rounded[31:0]});
    assign res     = 33'(log_bw) - term;

    assign out_free = !ov_reg || results.ready;
    assign pop      = (state_reg == B_IDLE) && !status.empty;

    assign results.valid    = ov_reg;
    assign results.cn0_dbhz = out_cn0_reg;
    assign results.outcome  = out_oc_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                im_reg  <= i_mag;
                qm_reg  <= q_mag;
                pim_reg <= prev_i_mag;
                pqm_reg <= prev_q_mag;
            end
            B_SQI: t_reg  <= mul_p[MUL_W-1:0];
            B_SQQ: s2_reg <= t_reg + mul_p[MUL_W-1:0];
            B_SPI: t_reg  <= mul_p[MUL_W-1:0];
            B_SPQ: sp_reg <= t_reg + mul_p[MUL_W-1:0];
            B_XS:  xs_reg <= mul_p;
            B_XT:  xt_reg <= mul_p;
            B_DIF:
            begin
                neg_reg <= (x_cur < p_cur);
                m_reg   <= (x_cur < p_cur) ? (p_cur - x_cur) : (x_cur - p_cur);
            end
            B_LO:  p1_reg <= mul_p;
            B_HI:  p2_reg <= mul_p;
            B_CHK:
            begin
                vn_reg   <= tot_reg - sig_reg;
                vs_reg   <= sig_reg;
                kn_reg   <= 6'd63;
                ks_reg   <= 6'd63;
            end
            B_NORM:
            begin
                if ((vn_reg & top_mask) == '0)
                begin
                    vn_reg <= vn_reg << sh;
                    kn_reg <= kn_reg - sh[5:0];
                end
                if ((vs_reg & top_mask) == '0)
                begin
                    vs_reg <= vs_reg << sh;
                    ks_reg <= ks_reg - sh[5:0];
                end
            end
            B_LOG: d_reg <= $signed({1'b0, lgn}) - $signed({1'b0, lgs});
            B_TERM:
            begin
                m_reg   <= mul_p;
                neg_reg <= d_reg[D_W-1];
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            sig_reg     <= '0;
            tot_reg     <= '0;
            est_reg     <= INIT_CN0_RESET;
            oc_reg      <= OUTC_RESTART;
            which_reg   <= 1'b0;
            step_reg    <= '0;
            ov_reg      <= 1'b0;
            out_cn0_reg <= INIT_CN0_RESET;
            out_oc_reg  <= OUTC_RESTART;
        end
        else
        begin
            if (ov_reg && results.ready && state_reg != B_OUT)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!status.empty)
                    begin
                        case (kind)
                            KIND_RESTART:
                            begin
                                sig_reg   <= '0;
                                tot_reg   <= '0;
                                est_reg   <= init_cn0;
                                oc_reg    <= OUTC_RESTART;
                                state_reg <= B_OUT;
                            end
                            KIND_FIRST:
                            begin
                                oc_reg    <= OUTC_FIRST;
                                state_reg <= B_OUT;
                            end
                            default:
                            begin
                                state_reg <= B_SQI;
                            end
                        endcase
                    end
                end
                B_SQI: state_reg <= B_SQQ;
                B_SQQ: state_reg <= B_SPI;
                B_SPI: state_reg <= B_SPQ;
                B_SPQ: state_reg <= B_XS;
                B_XS:  state_reg <= B_XT;
                B_XT:
                begin
                    which_reg <= 1'b0;
                    state_reg <= B_DIF;
                end
                B_DIF: state_reg <= B_LO;
                B_LO:  state_reg <= B_HI;
                B_HI:  state_reg <= B_UPD;
                B_UPD:
                begin
                    if (which_reg)
                    begin
                        tot_reg   <= p_new;
                        state_reg <= B_CHK;
                    end
                    else
                    begin
                        sig_reg   <= p_new;
                        which_reg <= 1'b1;
                        state_reg <= B_DIF;
                    end
                end
                B_CHK:
                begin
                    step_reg <= '0;
                    if (sig_reg == '0)
                    begin
                        oc_reg    <= OUTC_ZERO_SIG;
                        state_reg <= B_OUT;
                    end
                    else if (tot_reg < sig_reg)
                    begin
                        oc_reg    <= OUTC_NEG_NOISE;
                        state_reg <= B_OUT;
                    end
                    else if (tot_reg == sig_reg)
                    begin
                        est_reg   <= CN0_MAX;
                        oc_reg    <= OUTC_UPDATED;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        state_reg <= B_NORM;
                    end
                end
                B_NORM:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd5)
                    begin
                        state_reg <= B_LOG;
                    end
                end
                B_LOG:  state_reg <= B_TERM;
                B_TERM: state_reg <= B_FIN;
                B_FIN:
                begin
                    if (res > 33'(CN0_MAX))
                    begin
                        est_reg <= CN0_MAX;
                    end
                    else if (res < 33'(CN0_MIN))
                    begin
                        est_reg <= CN0_MIN;
                    end
                    else
                    begin
                        est_reg <= res[15:0];
                    end
                    oc_reg    <= OUTC_UPDATED;
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        ov_reg      <= 1'b1;
                        out_cn0_reg <= est_reg;
                        out_oc_reg  <= oc_reg;
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && out_free) |=> (ov_reg && state_reg == B_IDLE))
        else $error("result not loaded on output");
    a_power_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !sig_reg[PWR_W-1] && !tot_reg[PWR_W-1])
        else $error("smoothed power out of range");
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_NORM |-> (vn_reg != '0 && vs_reg != '0))
        else $error("log2 of zero");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_LOG |-> $past(step_reg) == 3'd5)
        else $error("normalize search cut short");

endmodule

[rtl/core/svr_cn0_estimator_core.sv]
// top level of the signal-to-variation c/n0 estimator
//
// channel   dir  beat
// samples   in   action, in_phase, quadrature
// results   out  cn0_dbhz, outcome
// cfg       in   index, data (alpha, log bandwidth, initial estimate)
//
// restart and first-sample beats go from the queue straight to the output state and result register;
// an updating sample is paced by the back part's single shared multiplier (squares, products,
// two-part smoothing) and, unless it holds or sees zero noise, the 6-step log2 search.
// reset clears powers, previous magnitudes and the estimate; registers take reset values.
// a 2-deep queue lets the front take beats while the back works or a result waits.
module svr_cn0_estimator_core #(
    parameter int SAMPLE_BITS   = 16,
    parameter int ALPHA_BITS    = 16,
    parameter int LOG_FRAC_BITS = 6
) (
    input logic        clk,
    input logic        rst_n,
    svr_sample_if.sink samples,
    svr_result_if.source results,
    svr_cfg_if.sink    cfg
);
    import svr_pkg::*;

    localparam int ENTRY_W = 2 + 4 * SAMPLE_BITS;

    logic [ALPHA_BITS:0]    alpha_reg;
    logic signed [15:0]     log_bw_reg;
    logic signed [15:0]     init_cn0_reg;

    fifo_status_t           status;
    logic                   push, pop;
    kind_t                  f_kind;
    logic [SAMPLE_BITS-1:0] f_im, f_qm, f_pim, f_pqm;
    logic [ENTRY_W-1:0]     push_data, pop_data;
    kind_t                  b_kind;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= (ALPHA_BITS + 1)'(ALPHA_RESET);
            log_bw_reg   <= LOG_BW_RESET;
            init_cn0_reg <= INIT_CN0_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ALPHA:    alpha_reg    <= cfg.data[ALPHA_BITS:0];
                CFG_LOG_BW:   log_bw_reg   <= cfg.data[15:0];
                CFG_INIT_CN0: init_cn0_reg <= cfg.data[15:0];
                default:      alpha_reg    <= alpha_reg;
            endcase
        end
    end

    svr_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .status     (status),
        .push       (push),
        .kind       (f_kind),
        .i_mag      (f_im),
        .q_mag      (f_qm),
        .prev_i_mag (f_pim),
        .prev_q_mag (f_pqm)
    );

    assign push_data = {f_kind, f_im, f_qm, f_pim, f_pqm};

    svr_fifo #(.W(ENTRY_W)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (status)
    );

    assign b_kind = kind_t'(pop_data[ENTRY_W-1 -: 2]);

    svr_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .ALPHA_BITS    (ALPHA_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .pop        (pop),
        .kind       (b_kind),
        .i_mag      (pop_data[4*SAMPLE_BITS-1 -: SAMPLE_BITS]),
        .q_mag      (pop_data[3*SAMPLE_BITS-1 -: SAMPLE_BITS]),
        .prev_i_mag (pop_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS]),
        .prev_q_mag (pop_data[SAMPLE_BITS-1:0]),
        .alpha      (alpha_reg),
        .log_bw     (log_bw_reg),
        .init_cn0   (init_cn0_reg),
        .results    (results)
    );

endmodule
